[hw/rtl/adsr_envelope_generator_assert.svh]
// Assertion macros shared by the envelope generator modules.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ADSR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ADSR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/adsr_pkg.sv]
// Shared constants, types and microprogram for the envelope generator.
`default_nettype none

package adsr_pkg;

   // Field and datapath widths.
   localparam int TIME_BITS      = 24;
   localparam int LEVEL_BITS     = 16;
   localparam int DELTA_BITS     = 12;
   localparam int OPCODE_BITS    = 2;
   localparam int STAGE_BITS     = 3;
   localparam int PROD_BITS      = TIME_BITS + LEVEL_BITS;
   localparam int CNT_BITS       = $clog2(LEVEL_BITS + 1);
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;
   localparam int STEP_BITS      = 3;
   localparam int BR_BITS        = 3;

   // Input opcodes.
   localparam logic [OPCODE_BITS-1:0] OP_TICK     = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_NOTE_ON  = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_NOTE_OFF = 2'd2;

   // Envelope stages.
   localparam logic [STAGE_BITS-1:0] STAGE_IDLE    = 3'd0;
   localparam logic [STAGE_BITS-1:0] STAGE_ATTACK  = 3'd1;
   localparam logic [STAGE_BITS-1:0] STAGE_DECAY   = 3'd2;
   localparam logic [STAGE_BITS-1:0] STAGE_SUSTAIN = 3'd3;
   localparam logic [STAGE_BITS-1:0] STAGE_RELEASE = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_ATTACK_LEVEL  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ATTACK_TICKS  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DECAY_TICKS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SUSTAIN_LEVEL = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SUSTAIN_MIN   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RELEASE_TICKS = 3'd5;

   // Branch kinds of the microprogram.
   localparam logic [BR_BITS-1:0] BR_NEXT        = 3'd0;
   localparam logic [BR_BITS-1:0] BR_WAIT_REQ    = 3'd1;
   localparam logic [BR_BITS-1:0] BR_IF_DIRECT   = 3'd2;
   localparam logic [BR_BITS-1:0] BR_IF_DIV_BUSY = 3'd3;
   localparam logic [BR_BITS-1:0] BR_WAIT_OUT    = 3'd4;

   // Program steps.
   localparam logic [STEP_BITS-1:0] STEP_FETCH    = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_UPDATE   = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_SETUP    = 3'd2;
   localparam logic [STEP_BITS-1:0] STEP_MUL      = 3'd3;
   localparam logic [STEP_BITS-1:0] STEP_DIV_INIT = 3'd4;
   localparam logic [STEP_BITS-1:0] STEP_DIV_STEP = 3'd5;
   localparam logic [STEP_BITS-1:0] STEP_FINISH   = 3'd6;
   localparam logic [STEP_BITS-1:0] STEP_OUTPUT   = 3'd7;

   // Datapath strobes driven by the sequencer.
   typedef struct packed {
      logic ld_in;
      logic upd;
      logic setup;
      logic mul;
      logic div_init;
      logic div_step;
      logic finish;
      logic out_wr;
   } ctrl_type;

   // Datapath conditions tested by the sequencer.
   typedef struct packed {
      logic direct;
      logic div_busy;
   } stat_type;

   // One control word of the program.
   typedef struct packed {
      ctrl_type              act;
      logic [BR_BITS-1:0]    br;
      logic [STEP_BITS-1:0]  target;
   } ucode_type;

   // Read-only program store.
   function automatic ucode_type ucode_rom(input logic [STEP_BITS-1:0] pc);
      ucode_type w;
      w = '0;
      case (pc)
         STEP_FETCH: begin
            w.act.ld_in = 1'b1;
            w.br        = BR_WAIT_REQ;
         end
         STEP_UPDATE: begin
            w.act.upd = 1'b1;
            w.br      = BR_NEXT;
         end
         STEP_SETUP: begin
            w.act.setup = 1'b1;
            w.br        = BR_IF_DIRECT;
            w.target    = STEP_OUTPUT;
         end
         STEP_MUL: begin
            w.act.mul = 1'b1;
            w.br      = BR_NEXT;
         end
         STEP_DIV_INIT: begin
            w.act.div_init = 1'b1;
            w.br           = BR_NEXT;
         end
         STEP_DIV_STEP: begin
            w.act.div_step = 1'b1;
            w.br           = BR_IF_DIV_BUSY;
            w.target       = STEP_DIV_STEP;
         end
         STEP_FINISH: begin
            w.act.finish = 1'b1;
            w.br         = BR_NEXT;
         end
         STEP_OUTPUT: begin
            w.act.out_wr = 1'b1;
            w.br         = BR_WAIT_OUT;
            w.target     = STEP_FETCH;
         end
         default: begin
            w.br     = BR_WAIT_OUT;
            w.target = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/adsr_envelope_generator.sv]
// Top level of the linear five-stage envelope generator.
//
// Each request word is a tick, a note-on or a note-off, and each produces exactly one
// response word holding the envelope level and stage after it. A small program in a
// read-only store steps the datapath through update, operand set-up, one 16 by 24
// multiply and a shift-subtract divide that yields one quotient bit a cycle. An item
// that interpolates presents its result after the 16 divider steps; in idle, in
// sustain or with a zero stage duration the level is known after set-up and the
// divider is skipped. The result sits in an output register, so the next request
// word is taken as soon as the program is back at its fetch step even if the
// previous response has not yet been taken. The user must write configuration
// registers through the csr port only while no item is in flight; the block
// itself does not enforce it.
`default_nettype none
`include "adsr_envelope_generator_assert.svh"

module adsr_envelope_generator
   import adsr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Request channel.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [15:0]               req_tdata,  // [11:0] tick_delta
   input  wire logic [OPCODE_BITS-1:0]    req_tuser,  // [1:0] opcode
   // Response channel.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [23:0]                    rsp_tdata,  // [15:0] level, [18:16] stage
   // Configuration write port.
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   ctrl_type              ctl;
   stat_type              stat;
   logic                  out_free;
   logic [LEVEL_BITS-1:0] dp_level;
   logic [STAGE_BITS-1:0] dp_stage;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_level_ff;
   logic [STAGE_BITS-1:0] rsp_stage_ff;

   // The output register may be refilled when empty or being emptied.
   assign out_free = !rsp_valid_ff || rsp_tready;

   adsr_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .stat       (stat),
      .req_tready (req_tready),
      .ctl        (ctl)
   );

   adsr_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .in_opcode (req_tuser),
      .in_delta  (req_tdata[DELTA_BITS-1:0]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .level     (dp_level),
      .stage     (dp_stage)
   );

   // Response word register.
   always_comb begin
      if (ctl.out_wr) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_wr) begin
         rsp_level_ff <= dp_level;
         rsp_stage_ff <= dp_stage;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24 - LEVEL_BITS - STAGE_BITS){1'b0}}, rsp_stage_ff, rsp_level_ff};

   `ADSR_ASSERT_IMP(a_no_overwrite, clock, reset, ctl.out_wr, out_free,
      "result written over a word still waiting")

endmodule

`default_nettype wire

[hw/rtl/adsr_sequencer.sv]
// Step counter and program store that steer the envelope datapath.
`default_nettype none
`include "adsr_envelope_generator_assert.svh"

module adsr_sequencer
   import adsr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   input  wire logic     out_free,
   input  wire stat_type stat,
   output logic          req_tready,
   output ctrl_type      ctl
);

   logic [STEP_BITS-1:0] pc_ff;
   logic [STEP_BITS-1:0] pc_in;
   logic [STEP_BITS-1:0] pc_inc;
   ucode_type            word;

   // Fetch the control word of the current step.
   assign word   = ucode_rom(pc_ff);
   assign pc_inc = pc_ff + STEP_BITS'(1);

   // Strobes fire only when the step's wait condition is met.
   always_comb begin
      ctl        = word.act;
      ctl.ld_in  = word.act.ld_in & req_tvalid;
      ctl.out_wr = word.act.out_wr & out_free;
      req_tready = word.act.ld_in;
   end

   // Next step from the branch kind of the control word.
   always_comb begin
      case (word.br)
         BR_NEXT:        pc_in = pc_inc;
         BR_WAIT_REQ:    pc_in = req_tvalid ? pc_inc : pc_ff;
         BR_IF_DIRECT:   pc_in = stat.direct ? word.target : pc_inc;
         BR_IF_DIV_BUSY: pc_in = stat.div_busy ? word.target : pc_inc;
         BR_WAIT_OUT:    pc_in = out_free ? word.target : pc_ff;
         default:        pc_in = STEP_FETCH;
      endcase
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `ADSR_ASSERT_NXT(a_fetch_to_update, clock, reset, ctl.ld_in, pc_ff == STEP_UPDATE,
      "accepted word did not move the program to the update step")
   `ADSR_ASSERT_NXT(a_direct_skips, clock, reset, ctl.setup && stat.direct,
      pc_ff == STEP_OUTPUT, "direct level did not skip the divider")
   `ADSR_ASSERT_NXT(a_out_returns, clock, reset, ctl.out_wr, pc_ff == STEP_FETCH,
      "program did not return to fetch after writing a result")

endmodule

`default_nettype wire

[hw/rtl/adsr_datapath.sv]
// Envelope state, configuration registers, multiplier and shift-subtract divider.
`default_nettype none
`include "adsr_envelope_generator_assert.svh"

module adsr_datapath
   import adsr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctrl_type                  ctl,
   input  wire logic [OPCODE_BITS-1:0]    in_opcode,
   input  wire logic [DELTA_BITS-1:0]     in_delta,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output stat_type                       stat,
   output logic [LEVEL_BITS-1:0]          level,
   output logic [STAGE_BITS-1:0]          stage
);

   // Configuration registers.
   logic [LEVEL_BITS-1:0] attack_level_ff;
   logic [TIME_BITS-1:0]  attack_ticks_ff;
   logic [TIME_BITS-1:0]  decay_ticks_ff;
   logic [LEVEL_BITS-1:0] sustain_level_ff;
   logic [TIME_BITS-1:0]  sustain_min_ff;
   logic [TIME_BITS-1:0]  release_ticks_ff;

   // Envelope state and the latched input word.
   logic [STAGE_BITS-1:0]  stage_ff, stage_in;
   logic                   gate_ff, gate_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [OPCODE_BITS-1:0] opcode_ff;
   logic [DELTA_BITS-1:0]  delta_ff;

   // Interpolation operands.
   logic                  direct_in;
   logic                  neg_ff, neg_in;
   logic [LEVEL_BITS-1:0] base_ff, base_in;
   logic [LEVEL_BITS-1:0] mcand_ff, mcand_in;
   logic [TIME_BITS-1:0]  mplier_ff, mplier_in;
   logic [TIME_BITS-1:0]  dur_ff, dur_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [PROD_BITS-1:0]  prod_ff;

   // Divider state.
   logic [TIME_BITS-1:0]  rem_ff;
   logic [LEVEL_BITS-1:0] low_ff;
   logic [LEVEL_BITS-1:0] quo_ff;
   logic [CNT_BITS-1:0]   cnt_ff;

   logic                  advance;
   logic [TIME_BITS-1:0]  tick_base;
   logic [TIME_BITS:0]    tick_sum;
   logic [TIME_BITS-1:0]  e_sat;
   logic [LEVEL_BITS-1:0] level_diff;
   logic [TIME_BITS:0]    trial;
   logic                  q_bit;

   // Configuration writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_level_ff  <= '1;
         attack_ticks_ff  <= '0;
         decay_ticks_ff   <= '0;
         sustain_level_ff <= '0;
         sustain_min_ff   <= '0;
         release_ticks_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ATTACK_LEVEL:  attack_level_ff  <= csr_wdata[LEVEL_BITS-1:0];
            REG_ATTACK_TICKS:  attack_ticks_ff  <= csr_wdata[TIME_BITS-1:0];
            REG_DECAY_TICKS:   decay_ticks_ff   <= csr_wdata[TIME_BITS-1:0];
            REG_SUSTAIN_LEVEL: sustain_level_ff <= csr_wdata[LEVEL_BITS-1:0];
            REG_SUSTAIN_MIN:   sustain_min_ff   <= csr_wdata[TIME_BITS-1:0];
            REG_RELEASE_TICKS: release_ticks_ff <= csr_wdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Stage transition, gate and timer update for one word.
   always_comb begin
      stage_in = stage_ff;
      gate_in  = gate_ff;
      advance  = 1'b0;
      case (opcode_ff)
         OP_TICK: begin
            case (stage_ff)
               STAGE_ATTACK: begin
                  if (elapsed_ff >= attack_ticks_ff) begin
                     stage_in = STAGE_DECAY;
                     advance  = 1'b1;
                  end
               end
               STAGE_DECAY: begin
                  if (elapsed_ff >= decay_ticks_ff) begin
                     stage_in = STAGE_SUSTAIN;
                     advance  = 1'b1;
                  end
               end
               STAGE_SUSTAIN: begin
                  if (!gate_ff && elapsed_ff >= sustain_min_ff) begin
                     stage_in = STAGE_RELEASE;
                     advance  = 1'b1;
                  end
               end
               STAGE_RELEASE: begin
                  if (elapsed_ff >= release_ticks_ff) begin
                     stage_in = STAGE_IDLE;
                     advance  = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         OP_NOTE_ON: begin
            if (stage_ff == STAGE_IDLE) begin
               stage_in = STAGE_ATTACK;
               gate_in  = 1'b1;
            end
         end
         OP_NOTE_OFF: gate_in = 1'b0;
         default: ;
      endcase
   end

   // Saturating timer advance; idle holds the timer at zero.
   assign tick_base = advance ? '0 : elapsed_ff;
   assign tick_sum  = {1'b0, tick_base} + (TIME_BITS+1)'(delta_ff);

   always_comb begin
      if (opcode_ff != OP_TICK) begin
         elapsed_in = elapsed_ff;
      end else if (stage_in == STAGE_IDLE) begin
         elapsed_in = '0;
      end else if (tick_sum[TIME_BITS]) begin
         elapsed_in = '1;
      end else begin
         elapsed_in = tick_sum[TIME_BITS-1:0];
      end
   end

   // Operand selection for the stage's interpolation.
   assign level_diff = (attack_level_ff >= sustain_level_ff) ?
                       (attack_level_ff - sustain_level_ff) :
                       (sustain_level_ff - attack_level_ff);

   always_comb begin
      direct_in = 1'b1;
      level_in  = '0;
      neg_in    = 1'b0;
      base_in   = '0;
      mcand_in  = '0;
      dur_in    = '1;
      case (stage_ff)
         STAGE_ATTACK: begin
            dur_in    = attack_ticks_ff;
            direct_in = (attack_ticks_ff == '0);
            level_in  = attack_level_ff;
            mcand_in  = attack_level_ff;
         end
         STAGE_DECAY: begin
            dur_in    = decay_ticks_ff;
            direct_in = (decay_ticks_ff == '0);
            level_in  = sustain_level_ff;
            mcand_in  = level_diff;
            base_in   = sustain_level_ff;
            neg_in    = (attack_level_ff < sustain_level_ff);
         end
         STAGE_SUSTAIN: level_in = sustain_level_ff;
         STAGE_RELEASE: begin
            dur_in    = release_ticks_ff;
            direct_in = (release_ticks_ff == '0);
            mcand_in  = sustain_level_ff;
         end
         default: ;
      endcase
   end

   // Elapsed time clipped to the duration; attack uses the elapsed time, the others the time left.
   assign e_sat     = (elapsed_ff < dur_in) ? elapsed_ff : dur_in;
   assign mplier_in = (stage_ff == STAGE_ATTACK) ? e_sat : (dur_in - e_sat);

   // One divider step: shift in a dividend bit and try the subtraction.
   assign trial = {rem_ff, low_ff[LEVEL_BITS-1]};
   assign q_bit = (trial >= {1'b0, dur_ff});

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= STAGE_IDLE;
         gate_ff    <= 1'b0;
         elapsed_ff <= '0;
         cnt_ff     <= '0;
      end else begin
         if (ctl.upd) begin
            stage_ff   <= stage_in;
            gate_ff    <= gate_in;
            elapsed_ff <= elapsed_in;
         end
         if (ctl.div_init) begin
            cnt_ff <= CNT_BITS'(LEVEL_BITS);
         end else if (ctl.div_step) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctl.ld_in) begin
         opcode_ff <= in_opcode;
         delta_ff  <= in_delta;
      end
      if (ctl.setup) begin
         neg_ff    <= neg_in;
         base_ff   <= base_in;
         mcand_ff  <= mcand_in;
         mplier_ff <= mplier_in;
         dur_ff    <= dur_in;
         level_ff  <= level_in;
      end
      if (ctl.mul) begin
         prod_ff <= PROD_BITS'(mcand_ff) * PROD_BITS'(mplier_ff);
      end
      if (ctl.div_init) begin
         rem_ff <= prod_ff[PROD_BITS-1:LEVEL_BITS];
         low_ff <= prod_ff[LEVEL_BITS-1:0];
         quo_ff <= '0;
      end else if (ctl.div_step) begin
         rem_ff <= q_bit ? TIME_BITS'(trial - {1'b0, dur_ff}) : trial[TIME_BITS-1:0];
         low_ff <= {low_ff[LEVEL_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[LEVEL_BITS-2:0], q_bit};
      end
      if (ctl.finish) begin
         level_ff <= neg_ff ? (base_ff - quo_ff) : (base_ff + quo_ff);
      end
   end

   assign stat.direct   = direct_in;
   assign stat.div_busy = (cnt_ff != CNT_BITS'(1));
   assign level         = level_ff;
   assign stage         = stage_ff;

   `ADSR_ASSERT_IMP(a_div_count, clock, reset, ctl.div_step, cnt_ff != '0,
      "divider stepped past its last quotient bit")
   `ADSR_ASSERT_NXT(a_div_loaded, clock, reset, ctl.div_init,
      cnt_ff == CNT_BITS'(LEVEL_BITS), "divider count not loaded")

endmodule

`default_nettype wire

[bench/tb_adsr_envelope_generator.sv]
// Self-checking testbench for the linear ADSR envelope generator, checked word by word.
module tb_adsr_envelope_generator
   import adsr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // The fourth opcode has no meaning and must leave the envelope alone.
   localparam logic [OPCODE_BITS-1:0] OP_RESERVED = 2'd3;
   localparam logic [TIME_BITS-1:0]   TIME_MAX    = '1;
   localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX   = '1;

   localparam int GAP_PERCENT   = 26;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_WORDS   = 56;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic [STAGE_BITS-1:0] stage;
   } envelope_out_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   // One directed row: either a request word or a register write.
   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_BITS-1:0]  index;
      logic [OPCODE_BITS-1:0]     op;
      logic [CSR_DATA_BITS-1:0]   value;
      logic                       typed;
      logic [LEVEL_BITS-1:0]      level;
      logic [STAGE_BITS-1:0]      stage;
   } stimulus_row_type;

   // Columns: kind, register, opcode, delta or register value, typed, level, stage.
   // The first block runs on the reset settings, where every duration is zero.
   // The second block uses a decay that rises towards a sustain level above the peak,
   // releases the gate during attack and drives the ratio past one.
   localparam stimulus_row_type DIRECTED [30] = '{
      '{ROW_WORD, '0, OP_TICK,     24'd0,     1'b1, 16'd0,     STAGE_IDLE},
      '{ROW_WORD, '0, OP_RESERVED, 24'd4095,  1'b1, 16'd0,     STAGE_IDLE},
      '{ROW_WORD, '0, OP_NOTE_OFF, 24'd0,     1'b1, 16'd0,     STAGE_IDLE},
      '{ROW_WORD, '0, OP_NOTE_ON,  24'd0,     1'b1, 16'd65535, STAGE_ATTACK},
      '{ROW_WORD, '0, OP_NOTE_ON,  24'd0,     1'b1, 16'd65535, STAGE_ATTACK},
      '{ROW_WORD, '0, OP_TICK,     24'd4095,  1'b1, 16'd0,     STAGE_DECAY},
      '{ROW_WORD, '0, OP_TICK,     24'd0,     1'b1, 16'd0,     STAGE_SUSTAIN},
      '{ROW_WORD, '0, OP_TICK,     24'd4095,  1'b1, 16'd0,     STAGE_SUSTAIN},
      '{ROW_WORD, '0, OP_NOTE_OFF, 24'd0,     1'b1, 16'd0,     STAGE_SUSTAIN},
      '{ROW_WORD, '0, OP_TICK,     24'hAAA,   1'b1, 16'd0,     STAGE_RELEASE},
      '{ROW_WORD, '0, OP_TICK,     24'h555,   1'b1, 16'd0,     STAGE_IDLE},
      // The peak level carries junk above bit 15, which the block must drop.
      '{ROW_CSR, REG_ATTACK_LEVEL,  '0, 24'hFF9C40, 1'b0, '0, '0},
      '{ROW_CSR, REG_ATTACK_TICKS,  '0, 24'd1000,   1'b0, '0, '0},
      '{ROW_CSR, REG_DECAY_TICKS,   '0, 24'd3000,   1'b0, '0, '0},
      '{ROW_CSR, REG_SUSTAIN_LEVEL, '0, 24'd60000,  1'b0, '0, '0},
      '{ROW_CSR, REG_SUSTAIN_MIN,   '0, 24'd500,    1'b0, '0, '0},
      '{ROW_CSR, REG_RELEASE_TICKS, '0, 24'd2000,   1'b0, '0, '0},
      '{ROW_WORD, '0, OP_NOTE_ON,  24'd0,     1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd500,   1'b0, '0, '0},
      '{ROW_WORD, '0, OP_NOTE_OFF, 24'd0,     1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd4095,  1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd0,     1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd1500,  1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd2000,  1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd1,     1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd600,   1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd7,     1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd1000,  1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd4095,  1'b0, '0, '0},
      '{ROW_WORD, '0, OP_TICK,     24'd0,     1'b0, '0, '0}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [15:0]               req_tdata;   // [11:0] tick_delta
   logic [OPCODE_BITS-1:0]    req_tuser;   // [1:0] opcode
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [23:0]               rsp_tdata;   // [15:0] level, [18:16] stage
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   bit               no_gaps = 1'b0;
   int               mismatches = 0;
   int               words_sent = 0;
   envelope_out_type expected_q [$];

   // Settings and state of the envelope as the bench expects them to be.
   logic [LEVEL_BITS-1:0] peak_level;
   logic [LEVEL_BITS-1:0] hold_level;
   logic [TIME_BITS-1:0]  attack_len;
   logic [TIME_BITS-1:0]  decay_len;
   logic [TIME_BITS-1:0]  hold_min_len;
   logic [TIME_BITS-1:0]  release_len;
   logic [STAGE_BITS-1:0] env_stage;
   logic                  env_gate;
   logic [TIME_BITS-1:0]  env_elapsed;

   adsr_envelope_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // floor(span * num / den); callers keep num within den, so the result fits.
   function automatic logic [LEVEL_BITS-1:0] interpolate(input logic [LEVEL_BITS-1:0] span,
                                                         input logic [TIME_BITS-1:0]  num,
                                                         input logic [TIME_BITS-1:0]  den);
      logic [PROD_BITS-1:0] prod;
      prod = ({{TIME_BITS{1'b0}}, span} * {{LEVEL_BITS{1'b0}}, num})
             / {{LEVEL_BITS{1'b0}}, den};
      return prod[LEVEL_BITS-1:0];
   endfunction

   // Level for the current stage, with the elapsed time clamped to the stage length.
   function automatic logic [LEVEL_BITS-1:0] envelope_level();
      logic [TIME_BITS-1:0] dur;
      logic [TIME_BITS-1:0] e;
      case (env_stage)
         STAGE_ATTACK: begin
            dur = attack_len;
            if (dur == '0) return peak_level;
            e = (env_elapsed < dur) ? env_elapsed : dur;
            return interpolate(peak_level, e, dur);
         end
         STAGE_DECAY: begin
            dur = decay_len;
            if (dur == '0) return hold_level;
            e = (env_elapsed < dur) ? env_elapsed : dur;
            if (peak_level >= hold_level)
               return hold_level + interpolate(peak_level - hold_level, dur - e, dur);
            return hold_level - interpolate(hold_level - peak_level, dur - e, dur);
         end
         STAGE_SUSTAIN: return hold_level;
         STAGE_RELEASE: begin
            dur = release_len;
            if (dur == '0) return '0;
            e = (env_elapsed < dur) ? env_elapsed : dur;
            return interpolate(hold_level, dur - e, dur);
         end
         default: return '0;
      endcase
   endfunction

   // Applies one request word to the expected state and returns the response it causes.
   function automatic envelope_out_type envelope_step(input logic [OPCODE_BITS-1:0] op,
                                                      input logic [DELTA_BITS-1:0]  delta);
      logic [TIME_BITS:0] sum;
      envelope_out_type   r;
      case (op)
         OP_TICK: begin
            // Stage change first, judged on the time before this tick.
            if (env_stage == STAGE_ATTACK && env_elapsed >= attack_len) begin
               env_elapsed = '0;
               env_stage   = STAGE_DECAY;
            end else if (env_stage == STAGE_DECAY && env_elapsed >= decay_len) begin
               env_elapsed = '0;
               env_stage   = STAGE_SUSTAIN;
            end else if (env_stage == STAGE_SUSTAIN && !env_gate
                         && env_elapsed >= hold_min_len) begin
               env_elapsed = '0;
               env_stage   = STAGE_RELEASE;
            end else if (env_stage == STAGE_RELEASE && env_elapsed >= release_len) begin
               env_elapsed = '0;
               env_stage   = STAGE_IDLE;
            end
            // The timer stays at zero in idle and saturates elsewhere.
            if (env_stage == STAGE_IDLE) begin
               env_elapsed = '0;
            end else begin
               sum = {1'b0, env_elapsed} + {{(TIME_BITS + 1 - DELTA_BITS){1'b0}}, delta};
               env_elapsed = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
            end
         end
         OP_NOTE_ON: begin
            if (env_stage == STAGE_IDLE) begin
               env_gate  = 1'b1;
               env_stage = STAGE_ATTACK;
            end
         end
         OP_NOTE_OFF: env_gate = 1'b0;
         default: ;
      endcase
      r.level = envelope_level();
      r.stage = env_stage;
      return r;
   endfunction

   // Random stage length: mostly short enough to finish, sometimes zero or huge.
   function automatic logic [CSR_DATA_BITS-1:0] pick_ticks();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20) return '0;
      if (roll < 40) return CSR_DATA_BITS'($urandom_range(64, 1));
      if (roll < 85) return CSR_DATA_BITS'($urandom_range(12000, 65));
      if (roll < 92) return TIME_MAX;
      return CSR_DATA_BITS'($urandom);
   endfunction

   // Random level, with random junk above the register width.
   function automatic logic [CSR_DATA_BITS-1:0] pick_level();
      logic [CSR_DATA_BITS-1:0] w;
      int                       roll;
      w    = CSR_DATA_BITS'($urandom);
      roll = $urandom_range(99);
      if (roll < 15) w[LEVEL_BITS-1:0] = '0;
      else if (roll < 30) w[LEVEL_BITS-1:0] = LEVEL_MAX;
      return w;
   endfunction

   // Tick delta: small steps give interior ratios, large ones cross stages quickly.
   function automatic logic [DELTA_BITS-1:0] pick_delta();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      if (roll < 50) return DELTA_BITS'($urandom_range(63, 1));
      return DELTA_BITS'($urandom);
   endfunction

   // Offers one request word, waits for it to be taken and records what must come back.
   task automatic send_word(input logic [OPCODE_BITS-1:0] op,
                            input logic [DELTA_BITS-1:0]  delta,
                            input logic                   typed,
                            input envelope_out_type       typed_out);
      envelope_out_type predicted;
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {{(16 - DELTA_BITS){1'b0}}, delta};
      do @(posedge clock); while (!req_tready);
      predicted = envelope_step(op, delta);
      expected_q.push_back(typed ? typed_out : predicted);
      words_sent++;
   endtask

   // Stops offering words and waits until every response is back.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0]  value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         REG_ATTACK_LEVEL:  peak_level   = value[LEVEL_BITS-1:0];
         REG_ATTACK_TICKS:  attack_len   = value[TIME_BITS-1:0];
         REG_DECAY_TICKS:   decay_len    = value[TIME_BITS-1:0];
         REG_SUSTAIN_LEVEL: hold_level   = value[LEVEL_BITS-1:0];
         REG_SUSTAIN_MIN:   hold_min_len = value[TIME_BITS-1:0];
         REG_RELEASE_TICKS: release_len  = value[TIME_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure_envelope(input logic [CSR_DATA_BITS-1:0] al,
                                     input logic [CSR_DATA_BITS-1:0] at,
                                     input logic [CSR_DATA_BITS-1:0] dt,
                                     input logic [CSR_DATA_BITS-1:0] sl,
                                     input logic [CSR_DATA_BITS-1:0] smin,
                                     input logic [CSR_DATA_BITS-1:0] rt);
      drain();
      write_reg(REG_ATTACK_LEVEL, al);
      write_reg(REG_ATTACK_TICKS, at);
      write_reg(REG_DECAY_TICKS, dt);
      write_reg(REG_SUSTAIN_LEVEL, sl);
      write_reg(REG_SUSTAIN_MIN, smin);
      write_reg(REG_RELEASE_TICKS, rt);
   endtask

   // Ticks after the gate is released until the envelope is back in idle, with a cap.
   task automatic run_out_release();
      for (int n = 0; n < 40 && env_stage != STAGE_IDLE; n++)
         send_word(OP_TICK, pick_delta(), 1'b0, '0);
   endtask

   // Response ready, gapped at random except in the steady stretch.
   always @(negedge clock)
      rsp_tready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);

   // Each response word is compared with the oldest expectation.
   always @(posedge clock) begin : check_response
      envelope_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: response with nothing expected: level %0d stage %0d",
                        $time, rsp_tdata[15:0], rsp_tdata[18:16]);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[15:0] !== want.level || rsp_tdata[18:16] !== want.stage) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: expected level %0d stage %0d, got level %0d stage %0d",
                           $time, want.level, want.stage, rsp_tdata[15:0],
                           rsp_tdata[18:16]);
               mismatches++;
            end
         end
      end
   end

   // Ends the run when no word moves on either channel for too long.
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stalled = 0;
         else
            stalled++;
      end
      $display("tb_adsr_envelope_generator: errors");
      $finish;
   end

   initial begin : stimulus
      int               off_at;
      int               start;
      stimulus_row_type row;
      envelope_out_type typed_out;

      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      reset      = 1'b1;
      peak_level   = LEVEL_MAX;
      hold_level   = '0;
      attack_len   = '0;
      decay_len    = '0;
      hold_min_len = '0;
      release_len  = '0;
      env_stage    = STAGE_IDLE;
      env_gate     = 1'b0;
      env_elapsed  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table.
      for (int i = 0; i < $size(DIRECTED); i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_CSR) begin
            drain();
            write_reg(row.index, row.value);
         end else begin
            typed_out.level = row.level;
            typed_out.stage = row.stage;
            send_word(row.op, row.value[DELTA_BITS-1:0], row.typed, typed_out);
         end
      end

      // Random phases, each on its own register setting.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0)
            configure_envelope({8'hA5, 16'h0000}, '0, '0, {8'h5A, LEVEL_MAX}, '0, '0);
         else if (p == 1)
            configure_envelope(LEVEL_MAX, TIME_MAX, TIME_MAX, '0, TIME_MAX, TIME_MAX);
         else
            configure_envelope(pick_level(), pick_ticks(), pick_ticks(), pick_level(),
                               pick_ticks(), pick_ticks());
         no_gaps = (p >= 5 && p <= 7);
         start   = words_sent;
         while (words_sent - start < PHASE_WORDS) begin
            if ($urandom_range(99) < 75) begin
               // A note: on, ticks with a release somewhere, then run out to idle.
               send_word(OP_NOTE_ON, DELTA_BITS'($urandom), 1'b0, '0);
               off_at = $urandom_range(24, 1);
               for (int n = 0; n < off_at; n++)
                  send_word(OP_TICK, pick_delta(), 1'b0, '0);
               send_word(OP_NOTE_OFF, DELTA_BITS'($urandom), 1'b0, '0);
               run_out_release();
            end else begin
               // Noise: any opcode in any state.
               repeat ($urandom_range(6, 1))
                  send_word(OPCODE_BITS'($urandom), DELTA_BITS'($urandom), 1'b0, '0);
            end
         end
      end
      no_gaps = 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("tb_adsr_envelope_generator: clean");
      else
         $display("tb_adsr_envelope_generator: errors");
      $finish;
   end

endmodule
